// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms used by the checker module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Clocked property that is also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== design/tpon_pkg.sv =====
// ----------------------------------------------------------------------------
// tpon_pkg
// Shared types and codes of the tileable Perlin octave noise block.
// ----------------------------------------------------------------------------
package tpon_pkg;

  // Datapath operation codes issued by the controller.
  localparam logic [4:0] OP_NONE  = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_DIV   = 5'd2;
  localparam logic [4:0] OP_PROD  = 5'd3;
  localparam logic [4:0] OP_SETUP = 5'd4;
  localparam logic [4:0] OP_FADE1 = 5'd5;
  localparam logic [4:0] OP_FADE2 = 5'd6;
  localparam logic [4:0] OP_FADE3 = 5'd7;
  localparam logic [4:0] OP_HMUL1 = 5'd8;
  localparam logic [4:0] OP_HMIX  = 5'd9;
  localparam logic [4:0] OP_HMUL3 = 5'd10;
  localparam logic [4:0] OP_HFIN  = 5'd11;
  localparam logic [4:0] OP_LERP0 = 5'd12;
  localparam logic [4:0] OP_LERP1 = 5'd13;
  localparam logic [4:0] OP_LERP2 = 5'd14;
  localparam logic [4:0] OP_ACCM  = 5'd15;
  localparam logic [4:0] OP_ACCA  = 5'd16;
  localparam logic [4:0] OP_FINIT = 5'd17;
  localparam logic [4:0] OP_FDIV  = 5'd18;
  localparam logic [4:0] OP_OUT   = 5'd19;

  // Hash operand selects: two column hashes, then the four corners.
  localparam logic [2:0] HSEL_X0  = 3'd0;
  localparam logic [2:0] HSEL_X1  = 3'd1;
  localparam logic [2:0] HSEL_C00 = 3'd2;
  localparam logic [2:0] HSEL_C01 = 3'd3;
  localparam logic [2:0] HSEL_C10 = 3'd4;
  localparam logic [2:0] HSEL_C11 = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] REG_SIZE  = 3'd0;
  localparam logic [2:0] REG_OCT   = 3'd1;
  localparam logic [2:0] REG_PERS  = 3'd2;
  localparam logic [2:0] REG_SEED  = 3'd3;
  localparam logic [2:0] REG_BASE  = 3'd4;
  localparam logic [2:0] REG_MULT1 = 3'd5;
  localparam logic [2:0] REG_ADD2  = 3'd6;
  localparam logic [2:0] REG_MULT3 = 3'd7;

  // Sequencing lengths.
  localparam logic [5:0] MOD_STEPS  = 6'd12;
  localparam logic [5:0] DIV_STEPS  = 6'd36;
  localparam logic [5:0] FDIV_STEPS = 6'd18;
  localparam logic [1:0] PH_LAST    = 2'd3;

  typedef struct packed {
    logic [4:0] op;
    logic [2:0] sel;
    logic [3:0] oct;
  } tpon_cmd_t;

  typedef struct packed {
    logic last_term;
  } tpon_sts_t;

endpackage

// ===== design/tpon_ctrl.sv =====
// ----------------------------------------------------------------------------
// tpon_ctrl
// Sequencer that steps the noise datapath through one texel.
// ----------------------------------------------------------------------------
module tpon_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  tpon_pkg::tpon_sts_t sts,
  output tpon_pkg::tpon_cmd_t cmd
);
  import tpon_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_MOD   = 5'd1;
  localparam logic [4:0] S_PROD  = 5'd2;
  localparam logic [4:0] S_DIV   = 5'd3;
  localparam logic [4:0] S_SETUP = 5'd4;
  localparam logic [4:0] S_FADE1 = 5'd5;
  localparam logic [4:0] S_FADE2 = 5'd6;
  localparam logic [4:0] S_FADE3 = 5'd7;
  localparam logic [4:0] S_HASH  = 5'd8;
  localparam logic [4:0] S_LERP0 = 5'd9;
  localparam logic [4:0] S_LERP1 = 5'd10;
  localparam logic [4:0] S_LERP2 = 5'd11;
  localparam logic [4:0] S_ACCM  = 5'd12;
  localparam logic [4:0] S_ACCA  = 5'd13;
  localparam logic [4:0] S_FINIT = 5'd14;
  localparam logic [4:0] S_FDIV  = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [4:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [2:0] mng_r, mng_nxt;
  logic [1:0] ph_r, ph_nxt;
  logic [3:0] oct_r, oct_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mng_nxt   = mng_r;
    ph_nxt    = ph_r;
    oct_nxt   = oct_r;
    cmd.op    = OP_NONE;
    cmd.sel   = mng_r;
    cmd.oct   = oct_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          cnt_nxt   = '0;
          state_nxt = S_MOD;
        end
      end
      S_MOD: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == MOD_STEPS - 6'd1) begin
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        cmd.op    = OP_PROD;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == DIV_STEPS - 6'd1) begin
          oct_nxt   = '0;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.op    = OP_SETUP;
        state_nxt = S_FADE1;
      end
      S_FADE1: begin
        cmd.op    = OP_FADE1;
        state_nxt = S_FADE2;
      end
      S_FADE2: begin
        cmd.op    = OP_FADE2;
        state_nxt = S_FADE3;
      end
      S_FADE3: begin
        cmd.op    = OP_FADE3;
        mng_nxt   = HSEL_X0;
        ph_nxt    = '0;
        state_nxt = S_HASH;
      end
      S_HASH: begin
        case (ph_r)
          2'd0:    cmd.op = OP_HMUL1;
          2'd1:    cmd.op = OP_HMIX;
          2'd2:    cmd.op = OP_HMUL3;
          default: cmd.op = OP_HFIN;
        endcase
        ph_nxt = ph_r + 2'd1;
        if (ph_r == PH_LAST) begin
          mng_nxt = mng_r + 3'd1;
          if (mng_r == HSEL_C11) begin
            state_nxt = S_LERP0;
          end
        end
      end
      S_LERP0: begin
        cmd.op    = OP_LERP0;
        state_nxt = S_LERP1;
      end
      S_LERP1: begin
        cmd.op    = OP_LERP1;
        state_nxt = S_LERP2;
      end
      S_LERP2: begin
        cmd.op    = OP_LERP2;
        state_nxt = S_ACCM;
      end
      S_ACCM: begin
        cmd.op    = OP_ACCM;
        state_nxt = S_ACCA;
      end
      S_ACCA: begin
        cmd.op = OP_ACCA;
        if (sts.last_term) begin
          state_nxt = S_FINIT;
        end else begin
          oct_nxt   = oct_r + 4'd1;
          state_nxt = S_SETUP;
        end
      end
      S_FINIT: begin
        cmd.op    = OP_FINIT;
        cnt_nxt   = '0;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        cmd.op  = OP_FDIV;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == FDIV_STEPS - 6'd1) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      mng_r       <= '0;
      ph_r        <= '0;
      oct_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      mng_r       <= mng_nxt;
      ph_r        <= ph_nxt;
      oct_r       <= oct_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/tpon_dp.sv =====
// ----------------------------------------------------------------------------
// tpon_dp
// Noise datapath: config registers, coordinate divider, fade, hash, lerp,
// octave accumulator and the final normalizing divider.
// ----------------------------------------------------------------------------
module tpon_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_wdata,
  input  logic [11:0]         texel_col,
  input  logic [11:0]         texel_row,
  input  tpon_pkg::tpon_cmd_t cmd,
  output tpon_pkg::tpon_sts_t sts,
  output logic [15:0]         noise_value
);
  import tpon_pkg::*;

  // Configuration registers.
  logic [12:0] size_r;
  logic [3:0]  oct_cnt_r;
  logic [15:0] pers_r;
  logic [31:0] seed_r;
  logic [7:0]  base_r;
  logic [31:0] m1_r;
  logic [31:0] a2_r;
  logic [31:0] m3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r    <= 13'd256;
      oct_cnt_r <= 4'd8;
      pers_r    <= 16'd26214;
      seed_r    <= 32'd0;
      base_r    <= 8'd23;
      m1_r      <= 32'd3039394381;
      a2_r      <= 32'd1759714724;
      m3_r      <= 32'd458671337;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE:  size_r    <= cfg_wdata[12:0];
        REG_OCT:   oct_cnt_r <= cfg_wdata[3:0];
        REG_PERS:  pers_r    <= cfg_wdata[15:0];
        REG_SEED:  seed_r    <= cfg_wdata;
        REG_BASE:  base_r    <= cfg_wdata[7:0];
        REG_MULT1: m1_r      <= cfg_wdata;
        REG_ADD2:  a2_r      <= cfg_wdata;
        REG_MULT3: m3_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [12:0] size_eff;
  logic [7:0]  base_eff;
  assign size_eff = (size_r == 13'd0) ? 13'd1 : size_r;
  assign base_eff = (base_r == 8'd0) ? 8'd1 : base_r;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [13:0] div_step(input logic [12:0] rem, input logic din,
                                           input logic [12:0] dvs);
    logic [13:0] t;
    logic [13:0] d;
    t = {rem, din};
    d = t - {1'b0, dvs};
    if (t >= {1'b0, dvs}) begin
      return {1'b1, d[12:0]};
    end
    return {1'b0, t[12:0]};
  endfunction

  // Signed lerp: a + floor((b - a) * t / 2^16).
  function automatic logic signed [18:0] lerp_f(input logic [16:0] t,
                                                input logic signed [18:0] a,
                                                input logic signed [18:0] b);
    logic signed [19:0] d;
    logic signed [37:0] p;
    logic signed [37:0] sh;
    d  = {b[18], b} - {a[18], a};
    p  = d * $signed({1'b0, t});
    sh = p >>> 16;
    return a + sh[18:0];
  endfunction

  // Coordinate lanes (column and row).
  logic [12:0] rem_c_r, rem_w_r;
  logic [35:0] dvd_c_r, dvd_w_r;
  logic [37:0] x_r, y_r;
  logic [13:0] ds_c, ds_w;
  logic        din_c, din_w;
  logic [19:0] cb_c, cb_w;

  assign din_c = (cmd.op == OP_DIV) ? dvd_c_r[35] : 1'b0;
  assign din_w = (cmd.op == OP_DIV) ? dvd_w_r[35] : 1'b0;
  assign ds_c  = div_step(rem_c_r, din_c, size_eff);
  assign ds_w  = div_step(rem_w_r, din_w, size_eff);
  assign cb_c  = rem_c_r[11:0] * base_eff;
  assign cb_w  = rem_w_r[11:0] * base_eff;

  // Lattice setup.
  logic [21:0] freq, gx0, gy0, gx0p, gy0p;
  assign freq = {14'd0, base_eff} << cmd.oct;
  assign gx0  = x_r[37:16];
  assign gy0  = y_r[37:16];
  assign gx0p = gx0 + 22'd1;
  assign gy0p = gy0 + 22'd1;

  logic [21:0] gx0_r, gx1_r, gy0_r, gy1_r;
  logic [15:0] fx_r, fy_r;

  // Fade lanes.
  logic [15:0] t2u_r, t2v_r, t3u_r, t3v_r;
  logic [19:0] pu_r, pv_r;
  logic [16:0] fade_u_r, fade_v_r;
  logic [31:0] sq_u, sq_v, cu_u, cu_v;
  logic [20:0] pu_w, pv_w;
  logic [35:0] fu_w, fv_w;

  assign sq_u = fx_r * fx_r;
  assign sq_v = fy_r * fy_r;
  assign cu_u = t2u_r * fx_r;
  assign cu_v = t2v_r * fy_r;
  assign pu_w = {5'd0, t2u_r} * 21'd6 + 21'd655360 - {5'd0, fx_r} * 21'd15;
  assign pv_w = {5'd0, t2v_r} * 21'd6 + 21'd655360 - {5'd0, fy_r} * 21'd15;
  assign fu_w = t3u_r * pu_r;
  assign fv_w = t3v_r * pv_r;

  // Hash unit.
  logic [31:0] hm_r, hx0_r, hx1_r;
  logic [31:0] hash_in, hv, mx1, mx2, mx3, mx4;
  logic [63:0] hp1, hp3;

  always_comb begin
    case (cmd.sel)
      HSEL_X0:  hash_in = {10'd0, gx0_r};
      HSEL_X1:  hash_in = {10'd0, gx1_r};
      HSEL_C00: hash_in = hx0_r + {10'd0, gy0_r};
      HSEL_C01: hash_in = hx0_r + {10'd0, gy1_r};
      HSEL_C10: hash_in = hx1_r + {10'd0, gy0_r};
      HSEL_C11: hash_in = hx1_r + {10'd0, gy1_r};
      default:  hash_in = '0;
    endcase
  end

  assign hp1 = hash_in * m1_r;
  assign hp3 = hm_r * m3_r;
  assign mx1 = hm_r + seed_r;
  assign mx2 = mx1 ^ (mx1 >> 8);
  assign mx3 = mx2 + a2_r;
  assign mx4 = mx3 ^ (mx3 << 8);
  assign hv  = hm_r ^ (hm_r >> 8);

  // Corner gradient from the finished hash.
  logic signed [17:0] dx0, dx1, dy0, dy1, dxs, dys;
  logic signed [18:0] grad;
  logic [1:0]         gi;

  assign dx0  = {2'b00, fx_r};
  assign dy0  = {2'b00, fy_r};
  assign dx1  = dx0 - 18'sd65536;
  assign dy1  = dy0 - 18'sd65536;
  assign dxs  = (cmd.sel inside {HSEL_C10, HSEL_C11}) ? dx1 : dx0;
  assign dys  = (cmd.sel inside {HSEL_C01, HSEL_C11}) ? dy1 : dy0;
  assign grad = (hv[1] ? -{dxs[17], dxs} : {dxs[17], dxs})
              + (hv[0] ? -{dys[17], dys} : {dys[17], dys});
  assign gi   = 2'(cmd.sel - HSEL_C00);

  logic signed [18:0] g_r [4];
  logic signed [18:0] la_r, lb_r, n_r;
  logic signed [18:0] lerp_a, lerp_b, lerp_y;
  logic [16:0]        lerp_t;

  always_comb begin
    case (cmd.op)
      OP_LERP0: begin
        lerp_t = fade_u_r;
        lerp_a = g_r[0];
        lerp_b = g_r[2];
      end
      OP_LERP1: begin
        lerp_t = fade_u_r;
        lerp_a = g_r[1];
        lerp_b = g_r[3];
      end
      default: begin
        lerp_t = fade_v_r;
        lerp_a = la_r;
        lerp_b = lb_r;
      end
    endcase
  end

  assign lerp_y = lerp_f(lerp_t, lerp_a, lerp_b);

  // Octave accumulator.
  logic [16:0]        amp_r;
  logic [20:0]        amp_sum_r;
  logic signed [38:0] total_r;
  logic signed [37:0] accp_r;
  logic [17:0]        amp_eff;
  logic signed [37:0] acc_p;
  logic [32:0]        amp_p;
  logic               has_oct;

  assign has_oct = (oct_cnt_r != 4'd0);
  assign amp_eff = ((cmd.oct == 4'd0) && has_oct) ? {amp_r, 1'b0} : {1'b0, amp_r};
  assign acc_p   = n_r * $signed({1'b0, amp_eff});
  assign amp_p   = amp_r * pers_r;

  assign sts.last_term = (({1'b0, cmd.oct} + 5'd1) >= {1'b0, oct_cnt_r});

  // Final normalizing divider.
  logic [20:0] frem_r;
  logic [17:0] flo_r;
  logic [17:0] q_r;
  logic        neg_r;
  logic [38:0] abs_w;
  logic [21:0] ft, fd;
  logic        fge;
  logic [15:0] mag, mag_c, out_r;

  assign abs_w = total_r[38] ? 39'(-total_r) : 39'(total_r);
  assign ft    = {frem_r, flo_r[17]};
  assign fd    = ft - {1'b0, amp_sum_r};
  assign fge   = (ft >= {1'b0, amp_sum_r});
  assign mag   = q_r[17:2];
  assign mag_c = (mag > 16'd16384) ? 16'd16384 : mag;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        dvd_c_r   <= {texel_col, 24'd0};
        dvd_w_r   <= {texel_row, 24'd0};
        rem_c_r   <= '0;
        rem_w_r   <= '0;
        total_r   <= '0;
        amp_r     <= 17'h10000;
        amp_sum_r <= 21'h10000;
      end
      OP_DIV: begin
        rem_c_r <= ds_c[12:0];
        rem_w_r <= ds_w[12:0];
        x_r     <= {x_r[36:0], ds_c[13]};
        y_r     <= {y_r[36:0], ds_w[13]};
        dvd_c_r <= {dvd_c_r[34:0], 1'b0};
        dvd_w_r <= {dvd_w_r[34:0], 1'b0};
      end
      OP_PROD: begin
        dvd_c_r <= {cb_c, 16'd0};
        dvd_w_r <= {cb_w, 16'd0};
        rem_c_r <= '0;
        rem_w_r <= '0;
        x_r     <= '0;
        y_r     <= '0;
      end
      OP_SETUP: begin
        gx0_r <= gx0;
        gy0_r <= gy0;
        gx1_r <= (gx0p == freq) ? 22'd0 : gx0p;
        gy1_r <= (gy0p == freq) ? 22'd0 : gy0p;
        fx_r  <= x_r[15:0];
        fy_r  <= y_r[15:0];
      end
      OP_FADE1: begin
        t2u_r <= sq_u[31:16];
        t2v_r <= sq_v[31:16];
      end
      OP_FADE2: begin
        t3u_r <= cu_u[31:16];
        t3v_r <= cu_v[31:16];
        pu_r  <= pu_w[19:0];
        pv_r  <= pv_w[19:0];
      end
      OP_FADE3: begin
        fade_u_r <= fu_w[32:16];
        fade_v_r <= fv_w[32:16];
      end
      OP_HMUL1: hm_r <= hp1[31:0];
      OP_HMIX:  hm_r <= mx4;
      OP_HMUL3: hm_r <= hp3[31:0];
      OP_HFIN: begin
        if (cmd.sel == HSEL_X0) begin
          hx0_r <= hv;
        end else if (cmd.sel == HSEL_X1) begin
          hx1_r <= hv;
        end else begin
          g_r[gi] <= grad;
        end
      end
      OP_LERP0: la_r <= lerp_y;
      OP_LERP1: lb_r <= lerp_y;
      OP_LERP2: n_r  <= lerp_y;
      OP_ACCM:  accp_r <= acc_p;
      OP_ACCA: begin
        total_r <= total_r + 39'(accp_r);
        if (has_oct) begin
          amp_sum_r <= amp_sum_r + {4'd0, amp_r};
          amp_r     <= amp_p[32:16];
        end
        // Next octave doubles the coordinate: one more quotient bit.
        rem_c_r <= ds_c[12:0];
        rem_w_r <= ds_w[12:0];
        x_r     <= {x_r[36:0], ds_c[13]};
        y_r     <= {y_r[36:0], ds_w[13]};
      end
      OP_FINIT: begin
        frem_r <= {1'b0, abs_w[37:18]};
        flo_r  <= abs_w[17:0];
        q_r    <= '0;
        neg_r  <= total_r[38];
      end
      OP_FDIV: begin
        frem_r <= fge ? fd[20:0] : ft[20:0];
        flo_r  <= {flo_r[16:0], 1'b0};
        q_r    <= {q_r[16:0], fge};
      end
      OP_OUT: out_r <= neg_r ? 16'(-mag_c) : mag_c;
      default: ;
    endcase
  end

  assign noise_value = out_r;

endmodule

// ===== design/tileable_perlin_octave_noise.sv =====
// ----------------------------------------------------------------------------
// tileable_perlin_octave_noise
// Fractal, tileable 2D Perlin noise generator, one texel per request.
// ----------------------------------------------------------------------------
// Usage. A request on the in_ stream carries one texel (column, row) of a
// square texture of texture_size texels per side. The block returns one
// result on the out_ stream: the texel's fractal noise value, signed Q2.14,
// clamped to [-1, 1]. Configuration registers are written over the cfg_
// port with a single-cycle write enable; write them only while idle.
//
// Timing. The block works on one request at a time. It runs octave_count
// octaves (one when octave_count is zero). It first reduces the coordinates
// modulo the texture size, then runs the bit-serial coordinate divider; each
// octave then does six hashes (multiply, mix, multiply and finish steps on one
// shared 32-bit hash multiplier set), fade and lerp steps and an accumulate;
// last, the bit-serial normalizing divider runs. The result is then loaded
// into the output register, and a new request is taken the cycle after that.
//
// Reset is synchronous and active low; it restores the register defaults and
// empties the output register. If the receiver stalls, the result waits in
// the output register while the next request is already accepted and
// computed; that one holds back only until the register frees.
// ----------------------------------------------------------------------------
module tileable_perlin_octave_noise (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [11:0] texel_col, [23:12] texel_row
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] noise_value
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import tpon_pkg::*;

  tpon_cmd_t cmd;
  tpon_sts_t sts;

  // Sequencer: handshakes and the op issued to the datapath each cycle.
  tpon_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: the texel is captured on the accepting cycle (OP_LOAD).
  tpon_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .texel_col   (in_tdata[11:0]),
    .texel_row   (in_tdata[23:12]),
    .cmd         (cmd),
    .sts         (sts),
    .noise_value (out_tdata)
  );

endmodule

// ===== design/tpon_chk.sv =====
// ----------------------------------------------------------------------------
// tpon_chk
// Port-level checks on the tileable Perlin octave noise block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpon_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // Reset empties the output register.
  `ASSERT_CLK_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid)

  // A stalled result holds its value.
  `ASSERT_CLK(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // One texel at a time: the block is busy right after taking a request.
  `ASSERT_CLK(a_busy, clk, rst_n, in_tvalid && in_tready |=> !in_tready)

  // Results stay within minus one to one in Q2.14.
  `ASSERT_CLK(a_range, clk, rst_n, out_tvalid |-> $signed(out_tdata) >= -16'sd16384 && $signed(out_tdata) <= 16'sd16384)

endmodule

bind tileable_perlin_octave_noise tpon_chk u_tpon_chk (.*);
